/* hdl/bpss_pkg.sv */
// shared constants and codes of the bridge pwm soft-start sequencer
`default_nettype none

package bpss_pkg;

  localparam int unsigned OP_W     = 2;
  localparam int unsigned FINE_W   = 8;
  localparam int unsigned MODE_W   = 2;
  localparam int unsigned CFG_IDX_W = 3;

  // event codes
  localparam logic [OP_W-1:0] OP_TICK    = 2'd0;
  localparam logic [OP_W-1:0] OP_BUTTON  = 2'd1;
  localparam logic [OP_W-1:0] OP_BATTERY = 2'd2;

  // run phases
  localparam logic [MODE_W-1:0] MODE_STOP   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_FINE   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_COARSE = 2'd2;
  localparam logic [MODE_W-1:0] MODE_RUN    = 2'd3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PWM_PERIOD  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEAD_BAND   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FINE_START  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FINE_END    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FINE_STEP   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_COARSE_STEP = 3'd5;

  // reset values and derived-value offsets
  localparam int unsigned RST_PERIOD      = 32'h190;
  localparam int unsigned RST_DEAD        = 32'h20;
  localparam logic [FINE_W-1:0] RST_FINE_START = 8'hFF;
  localparam logic [FINE_W-1:0] RST_FINE_END   = 8'h00;
  localparam int unsigned RST_STEP        = 1;
  localparam int unsigned GUARD_ADD       = 2;
  localparam int unsigned GUARD_EXTRA     = 4;
  localparam int unsigned OFF_OFFSET      = 2;
  localparam int unsigned LEG_OFFSET      = 3;

endpackage

`default_nettype wire

/* hdl/bpss_in_if.sv */
// input event channel: valid, ready and event payload
`default_nettype none

interface bpss_in_if
  import bpss_pkg::*;
();
  logic            valid;
  logic            ready;
  logic [OP_W-1:0] op;
  logic            battery_level;

  modport source (output valid, output op, output battery_level, input ready);
  modport sink   (input valid, input op, input battery_level, output ready);
endinterface

`default_nettype wire

/* hdl/bpss_out_if.sv */
// result channel: valid, ready and applied timer values
`default_nettype none

interface bpss_out_if
  import bpss_pkg::*;
#(
  parameter int unsigned COUNT_BITS = 16
) ();
  logic                  valid;
  logic                  ready;
  logic [COUNT_BITS-1:0] period_reg;
  logic [COUNT_BITS-1:0] compare_a;
  logic [FINE_W-1:0]     compare_a_fine;
  logic [COUNT_BITS-1:0] compare_b;
  logic [COUNT_BITS-1:0] phase_offset;
  logic [MODE_W-1:0]     run_phase;

  modport source (output valid, output period_reg, output compare_a, output compare_a_fine,
                  output compare_b, output phase_offset, output run_phase, input ready);
  modport sink   (input valid, input period_reg, input compare_a, input compare_a_fine,
                  input compare_b, input phase_offset, input run_phase, output ready);
endinterface

`default_nettype wire

/* hdl/bridge_pwm_soft_start_sequencer_top.sv */
// top level of the bridge pwm soft-start sequencer
//
//  channel | dir | transfer content
//  in_ch   | in  | op, battery_level
//  out_ch  | out | period_reg, compare_a, compare_a_fine, compare_b, phase_offset, run_phase
//  cfg_*   | in  | cfg_index, cfg_data on cfg_we
//
// one event per cycle: the whole step is a single pass from the state registers
// into the result register, so a result appears the cycle after its transfer.
// in_ch.ready is high while the result register is empty or being taken.
// a stall on out_ch holds the result and blocks further input transfers.
// synchronous active-low reset loads the state as after power-up, stopped.
`default_nettype none

module bridge_pwm_soft_start_sequencer_top
  import bpss_pkg::*;
#(
  parameter int unsigned COUNT_BITS = 16
) (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   cfg_we,
  input  wire [CFG_IDX_W-1:0]   cfg_index,
  input  wire [COUNT_BITS-1:0]  cfg_data,
  bpss_in_if.sink               in_ch,
  bpss_out_if.source            out_ch
);

  localparam int unsigned CB = COUNT_BITS;
  localparam int unsigned NW = CB + 3;

  localparam logic [CB-1:0] RST_P    = CB'(RST_PERIOD);
  localparam logic [CB-1:0] RST_DB   = CB'(RST_DEAD);
  localparam logic [CB-1:0] RST_OFF  = RST_P - CB'(OFF_OFFSET);
  localparam logic [CB-1:0] RST_ON   = (RST_P >> 1) + RST_DB;
  localparam logic [CB-1:0] RST_BW   = RST_P - RST_ON;
  localparam logic [CB-1:0] RST_LEG  = RST_P - CB'(LEG_OFFSET);

  function automatic logic [CB-1:0] toward(input logic [CB-1:0] cur,
                                           input logic [CB-1:0] target,
                                           input logic [CB-1:0] step_in);
    logic [CB-1:0] step;
    logic [CB-1:0] res;
    step = (step_in == '0) ? CB'(1) : step_in;
    if (cur > target) begin
      res = ((cur - target) <= step) ? target : (cur - step);
    end else begin
      res = ((target - cur) <= step) ? target : (cur + step);
    end
    return res;
  endfunction

  // configuration registers
  logic [CB-1:0]     pwm_period_r, dead_band_r, coarse_step_r;
  logic [FINE_W-1:0] fine_start_r, fine_end_r, fine_step_r;

  // sequencer state
  logic [MODE_W-1:0] mode_r, mode_nxt;
  logic [FINE_W-1:0] fine_now_r, fine_now_nxt;
  logic [CB-1:0]     coarse_now_r, coarse_now_nxt;
  logic [CB-1:0]     off_w_r, off_w_nxt;
  logic [CB-1:0]     on_w_r, on_w_nxt;
  logic [CB-1:0]     b_w_r, b_w_nxt;
  logic [CB-1:0]     leg_r, leg_nxt;
  logic [CB-1:0]     seen_r, seen_nxt;
  logic [CB-1:0]     app_period_r, app_period_nxt;
  logic [CB-1:0]     app_b_r, app_b_nxt;
  logic [CB-1:0]     app_phase_r, app_phase_nxt;

  // result register
  logic              out_valid_r;
  logic [CB-1:0]     out_period_r, out_cmp_a_r, out_cmp_b_r, out_phase_r;
  logic [FINE_W-1:0] out_fine_r;
  logic [MODE_W-1:0] out_mode_r;

  logic          in_xfer;
  logic [NW-1:0] need;
  logic          guard_ok;
  logic [CB-1:0] half_on;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_xfer     = in_ch.valid && in_ch.ready;

  assign need     = ((NW'(dead_band_r) + NW'(GUARD_ADD)) << 1) + NW'(GUARD_EXTRA);
  assign guard_ok = NW'(pwm_period_r) >= need;
  assign half_on  = (pwm_period_r >> 1) + dead_band_r;

  always_comb begin
    mode_nxt       = mode_r;
    fine_now_nxt   = fine_now_r;
    coarse_now_nxt = coarse_now_r;
    off_w_nxt      = off_w_r;
    on_w_nxt       = on_w_r;
    b_w_nxt        = b_w_r;
    leg_nxt        = leg_r;
    seen_nxt       = seen_r;
    app_period_nxt = app_period_r;
    app_b_nxt      = app_b_r;
    app_phase_nxt  = app_phase_r;

    // period change check ahead of the event
    if (seen_r != pwm_period_r) begin
      if (guard_ok) begin
        off_w_nxt = pwm_period_r - CB'(OFF_OFFSET);
        on_w_nxt  = half_on;
        b_w_nxt   = pwm_period_r - half_on;
        leg_nxt   = pwm_period_r - CB'(LEG_OFFSET);
      end
      seen_nxt = pwm_period_r;
      if (mode_r == MODE_RUN) begin
        app_period_nxt = pwm_period_r;
        app_b_nxt      = b_w_nxt;
        app_phase_nxt  = leg_nxt;
        coarse_now_nxt = on_w_nxt;
      end
    end

    unique case (in_ch.op)
      OP_TICK: begin
        if (mode_r == MODE_FINE) begin
          if (fine_now_nxt == fine_end_r) begin
            mode_nxt       = MODE_COARSE;
            coarse_now_nxt = off_w_nxt;
          end else begin
            fine_now_nxt = FINE_W'(toward(CB'(fine_now_nxt), CB'(fine_end_r),
                                          CB'(fine_step_r)));
          end
        end else if (mode_r == MODE_COARSE) begin
          if (coarse_now_nxt == on_w_nxt) begin
            mode_nxt = MODE_RUN;
          end else begin
            coarse_now_nxt = toward(coarse_now_nxt, on_w_nxt, coarse_step_r);
          end
        end
      end
      OP_BUTTON: begin
        app_period_nxt = pwm_period_r;
        app_b_nxt      = b_w_nxt;
        app_phase_nxt  = leg_nxt;
        coarse_now_nxt = off_w_nxt;
        fine_now_nxt   = fine_start_r;
        mode_nxt       = (mode_r == MODE_STOP) ? MODE_FINE : MODE_STOP;
      end
      OP_BATTERY: begin
        if (!in_ch.battery_level || mode_r == MODE_STOP || mode_r == MODE_RUN) begin
          app_period_nxt = pwm_period_r;
          app_b_nxt      = b_w_nxt;
          app_phase_nxt  = leg_nxt;
          coarse_now_nxt = off_w_nxt;
          fine_now_nxt   = fine_start_r;
          mode_nxt       = in_ch.battery_level ? MODE_FINE : MODE_STOP;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pwm_period_r  <= RST_P;
      dead_band_r   <= RST_DB;
      fine_start_r  <= RST_FINE_START;
      fine_end_r    <= RST_FINE_END;
      fine_step_r   <= FINE_W'(RST_STEP);
      coarse_step_r <= CB'(RST_STEP);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PWM_PERIOD:  pwm_period_r  <= cfg_data;
        CFG_DEAD_BAND:   dead_band_r   <= cfg_data;
        CFG_FINE_START:  fine_start_r  <= cfg_data[FINE_W-1:0];
        CFG_FINE_END:    fine_end_r    <= cfg_data[FINE_W-1:0];
        CFG_FINE_STEP:   fine_step_r   <= cfg_data[FINE_W-1:0];
        CFG_COARSE_STEP: coarse_step_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= MODE_STOP;
      fine_now_r   <= RST_FINE_START;
      coarse_now_r <= RST_OFF;
      off_w_r      <= RST_OFF;
      on_w_r       <= RST_ON;
      b_w_r        <= RST_BW;
      leg_r        <= RST_LEG;
      seen_r       <= RST_P;
      app_period_r <= RST_P;
      app_b_r      <= RST_BW;
      app_phase_r  <= RST_LEG;
    end else if (in_xfer) begin
      mode_r       <= mode_nxt;
      fine_now_r   <= fine_now_nxt;
      coarse_now_r <= coarse_now_nxt;
      off_w_r      <= off_w_nxt;
      on_w_r       <= on_w_nxt;
      b_w_r        <= b_w_nxt;
      leg_r        <= leg_nxt;
      seen_r       <= seen_nxt;
      app_period_r <= app_period_nxt;
      app_b_r      <= app_b_nxt;
      app_phase_r  <= app_phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_xfer) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      out_period_r <= app_period_nxt - CB'(1);
      out_cmp_a_r  <= coarse_now_nxt;
      out_fine_r   <= fine_now_nxt;
      out_cmp_b_r  <= app_b_nxt;
      out_phase_r  <= app_phase_nxt;
      out_mode_r   <= mode_nxt;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.period_reg     = out_period_r;
  assign out_ch.compare_a      = out_cmp_a_r;
  assign out_ch.compare_a_fine = out_fine_r;
  assign out_ch.compare_b      = out_cmp_b_r;
  assign out_ch.phase_offset   = out_phase_r;
  assign out_ch.run_phase      = out_mode_r;

endmodule

`default_nettype wire

/* hdl/bpss_checker.sv */
// port-level checks on the soft-start sequencer, bound to the top level
`default_nettype none

module bpss_checker
  import bpss_pkg::*;
#(
  parameter int unsigned COUNT_BITS = 16
) (
  input wire                  clk,
  input wire                  rst_n,
  input wire                  in_valid,
  input wire                  in_ready,
  input wire                  out_valid,
  input wire                  out_ready,
  input wire [COUNT_BITS-1:0] out_period_reg,
  input wire [COUNT_BITS-1:0] out_compare_a,
  input wire [MODE_W-1:0]     out_run_phase
);

  // a stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_period_reg)
      && $stable(out_compare_a) && $stable(out_run_phase))
    else $error("stalled result changed");

  // every input transfer shows a result in the next cycle
  a_in_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("input transfer gave no result");

  // an empty result register never blocks input
  a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input blocked with empty result register");

  // reset leaves no result pending
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result pending after reset");

endmodule

bind bridge_pwm_soft_start_sequencer_top bpss_checker #(
  .COUNT_BITS(COUNT_BITS)
) u_bpss_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_period_reg (out_ch.period_reg),
  .out_compare_a  (out_ch.compare_a),
  .out_run_phase  (out_ch.run_phase)
);

`default_nettype wire
